// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the deframer modules.
// Both expect aclk and aresetn in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock outside reset.
`define MPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define MPD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ----- hdl/mpd_pkg.sv -----
package mpd_pkg;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // "Content-Length:" plus one pad entry so a 4-bit index stays in range
    localparam logic [3:0] KEY_LAST = 4'd14;
    localparam logic [3:0] KEY_DONE = 4'd15;
    localparam logic [7:0] KEY_CHARS [16] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h00
    };

    typedef enum logic [1:0] {
        VP_NONE   = 2'd0,
        VP_BLANK  = 2'd1,
        VP_DIGITS = 2'd2,
        VP_DONE   = 2'd3
    } vphase_t;

    typedef enum logic [1:0] {
        EP_IDLE = 2'd0,
        EP_CR1  = 2'd1,
        EP_LF1  = 2'd2,
        EP_CR2  = 2'd3
    } endpos_t;

    // header scanner status towards frame control
    typedef struct packed {
        logic done;
        logic len_ok;
        logic len_zero;
    } hdr_evt_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       empty;
    } res_t;

endpackage

// ----- hdl/mpd_hdr_scan.sv -----
module mpd_hdr_scan #(
    parameter int LEN_WIDTH = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            byte_in,
    output mpd_pkg::hdr_evt_t     evt,
    output logic [LEN_WIDTH-1:0]  hdr_len
);

    mpd_pkg::endpos_t      end_pos_reg, end_pos_next;
    logic [3:0]            key_pos_reg, key_pos_next;
    mpd_pkg::vphase_t      vphase_reg, vphase_next;
    logic [LEN_WIDTH-1:0]  len_reg, len_next;

    logic                  is_digit;
    logic                  is_blank;
    logic [3:0]            digit;
    logic [LEN_WIDTH+3:0]  mac_wide;
    logic [LEN_WIDTH-1:0]  len_acc;
    logic                  header_end;

    assign is_digit = (byte_in >= mpd_pkg::CHAR_ZERO) && (byte_in <= mpd_pkg::CHAR_NINE);
    assign is_blank = (byte_in == mpd_pkg::CHAR_SP) || (byte_in == mpd_pkg::CHAR_TAB);
    assign digit    = byte_in[3:0];

    // len * 10 + digit as (len << 3) + (len << 1) + digit, saturating
    assign mac_wide = {1'b0, len_reg, 3'b000} + {3'b000, len_reg, 1'b0}
                    + {{LEN_WIDTH{1'b0}}, digit};
    assign len_acc  = (|mac_wide[LEN_WIDTH+3:LEN_WIDTH]) ? '1 : mac_wide[LEN_WIDTH-1:0];

    assign header_end = (end_pos_reg == mpd_pkg::EP_CR2) && (byte_in == mpd_pkg::CHAR_LF);

    always_comb begin
        key_pos_next = key_pos_reg;
        vphase_next  = vphase_reg;
        len_next     = len_reg;
        if (key_pos_reg != mpd_pkg::KEY_DONE) begin
            if (byte_in == mpd_pkg::KEY_CHARS[key_pos_reg]) begin
                if (key_pos_reg == mpd_pkg::KEY_LAST) begin
                    key_pos_next = mpd_pkg::KEY_DONE;
                    vphase_next  = mpd_pkg::VP_BLANK;
                    len_next     = '0;
                end else begin
                    key_pos_next = key_pos_reg + 4'd1;
                end
            end else begin
                key_pos_next = (byte_in == mpd_pkg::KEY_CHARS[0]) ? 4'd1 : 4'd0;
            end
        end else begin
            unique case (vphase_reg)
                mpd_pkg::VP_BLANK: begin
                    if (!is_blank) begin
                        if (is_digit) begin
                            len_next    = {{(LEN_WIDTH-4){1'b0}}, digit};
                            vphase_next = mpd_pkg::VP_DIGITS;
                        end else begin
                            vphase_next = mpd_pkg::VP_NONE;
                        end
                    end
                end
                mpd_pkg::VP_DIGITS: begin
                    if (is_digit) begin
                        len_next = len_acc;
                    end else begin
                        vphase_next = mpd_pkg::VP_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (end_pos_reg)
            mpd_pkg::EP_IDLE:
                end_pos_next = (byte_in == mpd_pkg::CHAR_CR) ? mpd_pkg::EP_CR1 : mpd_pkg::EP_IDLE;
            mpd_pkg::EP_LF1:
                end_pos_next = (byte_in == mpd_pkg::CHAR_CR) ? mpd_pkg::EP_CR2 : mpd_pkg::EP_IDLE;
            mpd_pkg::EP_CR1: begin
                if (byte_in == mpd_pkg::CHAR_LF) begin
                    end_pos_next = mpd_pkg::EP_LF1;
                end else begin
                    end_pos_next = (byte_in == mpd_pkg::CHAR_CR) ? mpd_pkg::EP_CR1
                                                                 : mpd_pkg::EP_IDLE;
                end
            end
            default: begin
                // EP_CR2: LF here is the header end and wraps to idle
                end_pos_next = (byte_in == mpd_pkg::CHAR_CR && !header_end)
                             ? mpd_pkg::EP_CR1 : mpd_pkg::EP_IDLE;
            end
        endcase
    end

    assign evt.done     = header_end;
    assign evt.len_ok   = (vphase_next == mpd_pkg::VP_DIGITS) || (vphase_next == mpd_pkg::VP_DONE);
    assign evt.len_zero = (len_next == '0);
    assign hdr_len      = len_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_pos_reg <= mpd_pkg::EP_IDLE;
            key_pos_reg <= 4'd0;
            vphase_reg  <= mpd_pkg::VP_NONE;
            len_reg     <= '0;
        end else if (step) begin
            if (header_end) begin
                end_pos_reg <= mpd_pkg::EP_IDLE;
                key_pos_reg <= 4'd0;
                vphase_reg  <= mpd_pkg::VP_NONE;
                len_reg     <= '0;
            end else begin
                end_pos_reg <= end_pos_next;
                key_pos_reg <= key_pos_next;
                vphase_reg  <= vphase_next;
                len_reg     <= len_next;
            end
        end
    end

endmodule

// ----- hdl/mpd_frame_ctl.sv -----
`include "assert_macros.svh"

module mpd_frame_ctl #(
    parameter int LEN_WIDTH = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [7:0]            byte_in,
    input  mpd_pkg::hdr_evt_t     evt,
    input  logic [LEN_WIDTH-1:0]  hdr_len,
    output logic                  hdr_step,
    output mpd_pkg::res_t         res,
    output logic                  res_vld
);

    logic                  in_payload_reg;
    logic [LEN_WIDTH-1:0]  bytes_left_reg;
    logic                  first_pending_reg;
    logic                  payload_active;
    logic                  frame_start;

    assign payload_active = in_payload_reg && (bytes_left_reg != '0);
    assign hdr_step       = advance && !payload_active;
    assign frame_start    = evt.done && evt.len_ok && !evt.len_zero;

    always_comb begin
        if (payload_active) begin
            res_vld   = 1'b1;
            res.data  = byte_in;
            res.first = first_pending_reg;
            res.last  = (bytes_left_reg == LEN_WIDTH'(1));
            res.empty = 1'b0;
        end else begin
            // zero length header gives a single empty-frame word
            res_vld   = evt.done && evt.len_ok && evt.len_zero;
            res.data  = 8'h00;
            res.first = 1'b1;
            res.last  = 1'b1;
            res.empty = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg    <= 1'b0;
            bytes_left_reg    <= '0;
            first_pending_reg <= 1'b0;
        end else if (advance) begin
            if (payload_active) begin
                first_pending_reg <= 1'b0;
                bytes_left_reg    <= bytes_left_reg - LEN_WIDTH'(1);
                if (bytes_left_reg == LEN_WIDTH'(1)) begin
                    in_payload_reg <= 1'b0;
                end
            end else if (frame_start) begin
                in_payload_reg    <= 1'b1;
                bytes_left_reg    <= hdr_len;
                first_pending_reg <= 1'b1;
            end else begin
                in_payload_reg <= 1'b0;
            end
        end
    end

    `MPD_ASSERT(a_frame_start, (hdr_step && frame_start) |=> (in_payload_reg && first_pending_reg), "frame did not start after header")
    `MPD_ASSERT(a_count_down, (advance && payload_active) |=> (bytes_left_reg == $past(bytes_left_reg) - LEN_WIDTH'(1)), "payload count slipped")
    `MPD_NEVER(a_payload_nonzero, in_payload_reg && (bytes_left_reg == '0), "payload phase with nothing left")

endmodule

// ----- hdl/mjpeg_part_deframer_top.sv -----
// Multipart MJPEG deframer.
// Slave stream (s_*): one raw stream byte per word in s_tdata[7:0].
// Master stream (m_*): frame payload words. m_tdata carries the byte,
// m_tlast marks the final word of a frame, m_tuser[0] the first word and
// m_tuser[1] an empty frame (header announced length zero; tdata is zero).
// Header bytes and dropped headers produce no output word.
// Throughput: one byte per cycle while m_tready is high. Each byte passes
// an input register, the header/payload update and an output register;
// its result word is registered onto m_* as the byte leaves the input register.
// A byte can be taken while a finished word still waits on m_*; when the
// receiver holds m_tready low the input register fills and s_tready drops
// only once both registers hold a word.
// Reset (aresetn low, synchronous) empties both registers and returns the
// block to the header search. A frame cut short by the stream is not
// withdrawn; words already sent stay sent.
// LEN_WIDTH sets the length counter; longer lengths saturate.
`include "assert_macros.svh"

module mjpeg_part_deframer_top #(
    parameter int LEN_WIDTH = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] frame_first, [1] frame_empty
);

    logic               in_vld_reg;
    logic [7:0]         in_byte_reg;
    logic               out_vld_reg;
    mpd_pkg::res_t      out_res_reg;

    logic               advance;
    logic               hdr_step;
    mpd_pkg::hdr_evt_t  evt;
    logic [LEN_WIDTH-1:0] hdr_len;
    mpd_pkg::res_t      res;
    logic               res_vld;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    mpd_hdr_scan #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_hdr_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (hdr_step),
        .byte_in (in_byte_reg),
        .evt     (evt),
        .hdr_len (hdr_len)
    );

    mpd_frame_ctl #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_frame_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .byte_in  (in_byte_reg),
        .evt      (evt),
        .hdr_len  (hdr_len),
        .hdr_step (hdr_step),
        .res      (res),
        .res_vld  (res_vld)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= res_vld;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_res_reg.data;
    assign m_tlast    = out_res_reg.last;
    assign m_tuser[0] = out_res_reg.first;
    assign m_tuser[1] = out_res_reg.empty;

    `MPD_ASSERT(a_in_hold, (in_vld_reg && out_vld_reg && !m_tready) |=> (in_vld_reg && $stable(in_byte_reg)), "input word lost while output stalled")
    `MPD_NEVER(a_ready_when_empty, !in_vld_reg && !s_tready, "input register empty but not ready")
    `MPD_ASSERT(a_out_source, $rose(out_vld_reg) |-> $past(advance), "output word without a processed byte")

endmodule
